// ===== rtl/cpt_pkg.sv =====
`default_nettype none

package cpt_pkg;

  // Most results one input item can cause
  localparam int MaxRes = 4;
  localparam int CntW   = $clog2(MaxRes + 1);

  // Characters the tokenizer reacts to
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // Result kinds
  typedef enum logic [2:0] {
    K_KEY     = 3'd0,
    K_VAL     = 3'd1,
    K_STORED  = 3'd2,
    K_DROPPED = 3'd3,
    K_DONE    = 3'd4
  } kind_t;

  // Parser phase
  typedef enum logic [6:0] {
    P_SKIP_KEY  = 7'b0000001,
    P_KEY       = 7'b0000010,
    P_AFTER_KEY = 7'b0000100,
    P_SKIP_VAL  = 7'b0001000,
    P_VAL       = 7'b0010000,
    P_AFTER_VAL = 7'b0100000,
    P_IGNORE    = 7'b1000000
  } parse_t;

  // Percent-escape progress
  typedef enum logic [2:0] {
    E_NONE = 3'b001,
    E_PCT  = 3'b010,
    E_HEX1 = 3'b100
  } esc_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  // Everything the step logic decides for one item
  typedef struct packed {
    logic [CntW-1:0]            n;
    result_t [MaxRes-1:0]       res;
    parse_t                     parse_next;
    esc_t                       esc_next;
    logic [7:0]                 held_next;
  } step_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  // Nibble value of a hex digit; 0 for anything else
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) v = c - 8'h30;
    else if ((c >= 8'h41) && (c <= 8'h46)) v = c - 8'h37;
    else if ((c >= 8'h61) && (c <= 8'h66)) v = c - 8'h57;
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cpt_in_if.sv =====
`default_nettype none

interface cpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/cpt_out_if.sv =====
`default_nettype none

interface cpt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic       last;

  modport source (output valid, output out_byte, output out_kind, output last, input ready);
  modport sink   (input valid, input out_byte, input out_kind, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/cpt_step.sv =====
`default_nettype none

module cpt_step (
  input  cpt_pkg::parse_t parse_phase,
  input  cpt_pkg::esc_t   escape_phase,
  input  logic [7:0]      held_hex_char,
  input  logic [7:0]      c,
  output cpt_pkg::step_t  step
);
  import cpt_pkg::*;

  logic [CntW-1:0]      n;
  result_t [MaxRes-1:0] res;
  parse_t               pn;
  esc_t                 en;
  logic [7:0]           hn;
  logic                 run_field;
  logic                 fld_key;
  esc_t                 fld_esc;
  kind_t                fk;
  logic                 stop;
  logic                 after_key;
  logic                 after_val;
  logic                 term;

  // One item through the phase logic; a byte may fall through up to three phases
  always_comb begin
    n         = '0;
    res       = '0;
    pn        = parse_phase;
    en        = escape_phase;
    hn        = held_hex_char;
    run_field = 1'b0;
    fld_key   = 1'b0;
    fld_esc   = escape_phase;
    fk        = K_KEY;
    stop      = 1'b0;
    after_key = 1'b0;
    after_val = 1'b0;
    term      = 1'b0;

    unique case (parse_phase)
      P_KEY: begin
        run_field = 1'b1;
        fld_key   = 1'b1;
      end
      P_VAL: begin
        run_field = 1'b1;
      end
      P_AFTER_KEY: after_key = 1'b1;
      P_AFTER_VAL: after_val = 1'b1;
      P_SKIP_VAL: begin
        if (c == CH_SPACE) begin
        end else if (c == CH_NUL) begin
          res[n[1:0]] = '{data: 8'h00, kind: K_STORED};
          n = n + 1'b1;
          res[n[1:0]] = '{data: 8'h00, kind: K_DONE};
          n = n + 1'b1;
          pn = P_SKIP_KEY;
        end else begin
          run_field = 1'b1;
        end
      end
      P_IGNORE: begin
        if (c == CH_NUL) begin
          res[n[1:0]] = '{data: 8'h00, kind: K_DONE};
          n = n + 1'b1;
          pn = P_SKIP_KEY;
        end
      end
      default: begin
        // before key, skipping spaces
        pn = P_SKIP_KEY;
        if (c == CH_SPACE) begin
        end else if (c == CH_NUL) begin
          res[n[1:0]] = '{data: 8'h00, kind: K_DONE};
          n = n + 1'b1;
        end else begin
          run_field = 1'b1;
          fld_key   = 1'b1;
          fld_esc   = E_NONE;
        end
      end
    endcase

    // Key or value byte, with escape handling
    if (run_field) begin
      fk = fld_key ? K_KEY : K_VAL;
      pn = fld_key ? P_KEY : P_VAL;
      en = E_NONE;
      if (fld_esc == E_PCT) begin
        if (is_hex(c)) begin
          hn   = c;
          en   = E_HEX1;
          stop = 1'b1;
        end else begin
          res[n[1:0]] = '{data: CH_PCT, kind: fk};
          n = n + 1'b1;
        end
      end else if (fld_esc == E_HEX1) begin
        if (is_hex(c)) begin
          res[n[1:0]] = '{data: {hex_val(held_hex_char), hex_val(c)}, kind: fk};
          n = n + 1'b1;
          stop = 1'b1;
        end else begin
          res[n[1:0]] = '{data: CH_PCT, kind: fk};
          n = n + 1'b1;
          res[n[1:0]] = '{data: held_hex_char, kind: fk};
          n = n + 1'b1;
        end
      end
      term = (c == CH_NUL) || (c == CH_SPACE) || (c == CH_SEMI) ||
             (fld_key && (c == CH_EQ));
      if (!stop) begin
        if (term) begin
          after_key = fld_key;
          after_val = !fld_key;
        end else if (c == CH_PLUS) begin
          res[n[1:0]] = '{data: CH_SPACE, kind: fk};
          n = n + 1'b1;
        end else if (c == CH_PCT) begin
          en = E_PCT;
        end else begin
          res[n[1:0]] = '{data: c, kind: fk};
          n = n + 1'b1;
        end
      end
    end

    // After a key: expect '='
    if (after_key) begin
      pn = P_AFTER_KEY;
      if (c == CH_SPACE) begin
      end else if (c == CH_NUL) begin
        res[n[1:0]] = '{data: 8'h00, kind: K_STORED};
        n = n + 1'b1;
        res[n[1:0]] = '{data: 8'h00, kind: K_DONE};
        n = n + 1'b1;
        pn = P_SKIP_KEY;
      end else if (c == CH_EQ) begin
        pn = P_SKIP_VAL;
      end else begin
        res[n[1:0]] = '{data: 8'h00, kind: K_DROPPED};
        n = n + 1'b1;
        pn = P_IGNORE;
      end
    end

    // After a value: expect ';' or end
    if (after_val) begin
      pn = P_AFTER_VAL;
      if (c == CH_SPACE) begin
      end else if (c == CH_NUL) begin
        res[n[1:0]] = '{data: 8'h00, kind: K_STORED};
        n = n + 1'b1;
        res[n[1:0]] = '{data: 8'h00, kind: K_DONE};
        n = n + 1'b1;
        pn = P_SKIP_KEY;
      end else if (c == CH_SEMI) begin
        res[n[1:0]] = '{data: 8'h00, kind: K_STORED};
        n = n + 1'b1;
        pn = P_SKIP_KEY;
      end else begin
        res[n[1:0]] = '{data: 8'h00, kind: K_DROPPED};
        n = n + 1'b1;
        pn = P_SKIP_KEY;
      end
    end

    step.n          = n;
    step.res        = res;
    step.parse_next = pn;
    step.esc_next   = en;
    step.held_next  = hn;
  end

endmodule

`default_nettype wire

// ===== rtl/cpt_rbuf.sv =====
`default_nettype none

module cpt_rbuf (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [cpt_pkg::CntW-1:0]        load_n,
  input  cpt_pkg::result_t [cpt_pkg::MaxRes-1:0] load_res,
  output logic                            free,
  cpt_out_if.source                       out
);
  import cpt_pkg::*;

  result_t [MaxRes-1:0] slot;
  logic [CntW-1:0]      rem;
  logic                 take;

  assign take = out.valid && out.ready;
  // Buffer can take a new item once its last result leaves
  assign free = (rem == '0) || ((rem == CntW'(1)) && out.ready);

  // Count of results still to deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= load_n;
    end else if (take) begin
      rem <= rem - 1'b1;
    end
  end

  // Result slots shift toward the head as results leave
  always_ff @(posedge clk) begin
    if (load) begin
      slot <= load_res;
    end else if (take) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  assign out.valid    = (rem != '0);
  assign out.out_byte = slot[0].data;
  assign out.out_kind = slot[0].kind;
  assign out.last     = (rem == CntW'(1));

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    rem <= CntW'(MaxRes))
    else $error("result count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (free && (load_n != '0)))
    else $error("load into busy buffer or with no results");

  a_drain_on: assert property (@(posedge clk) disable iff (rst)
    (take && !load && (rem > CntW'(1))) |=> out.valid)
    else $error("pending results lost");

endmodule

`default_nettype wire

// ===== rtl/cookie_pair_tokenizer_unescape.sv =====
// A result passes the input register, then the result buffer, before it is
// offered. Throughput: one input item per cycle while out.ready is high and
// each item yields at most one result; an item yielding several results
// holds the next item back until its last result leaves. The result buffer
// (four slots, one result out per cycle while ready) sets that figure.
// Reset (rst, synchronous): phase returns to skipping spaces before a key,
// no escape pending, held digit cleared, input and result stages emptied.
`default_nettype none

module cookie_pair_tokenizer_unescape (
  input  logic      clk,
  input  logic      rst,
  cpt_in_if.sink    in,
  cpt_out_if.source out
);
  import cpt_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_move;
  logic       rb_free;
  logic       rb_load;
  parse_t     parse_phase;
  esc_t       escape_phase;
  logic [7:0] held_hex_char;
  step_t      step;

  assign s1_move  = s1_valid && rb_free;
  assign rb_load  = s1_move && (step.n != '0);
  assign in.ready = !s1_valid || s1_move;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in.ready) begin
      s1_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.ready && in.valid) begin
      s1_byte <= in.in_byte;
    end
  end

  // Parser state advances when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= P_SKIP_KEY;
      escape_phase  <= E_NONE;
      held_hex_char <= 8'h00;
    end else if (s1_move) begin
      parse_phase   <= step.parse_next;
      escape_phase  <= step.esc_next;
      held_hex_char <= step.held_next;
    end
  end

  cpt_step u_step (
    .parse_phase   (parse_phase),
    .escape_phase  (escape_phase),
    .held_hex_char (held_hex_char),
    .c             (s1_byte),
    .step          (step)
  );

  cpt_rbuf u_rbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (rb_load),
    .load_n   (step.n),
    .load_res (step.res),
    .free     (rb_free),
    .out      (out)
  );

  a_hold_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> (s1_valid && $stable(s1_byte)))
    else $error("stalled item lost from input register");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_move |=> ($stable(parse_phase) && $stable(escape_phase) && $stable(held_hex_char)))
    else $error("parser state changed without an item");

  a_esc_in_field: assert property (@(posedge clk) disable iff (rst)
    (escape_phase != E_NONE) |-> ((parse_phase == P_KEY) || (parse_phase == P_VAL)))
    else $error("escape pending outside key or value");

endmodule

`default_nettype wire
